// ===== rtl/brle_pkg.sv =====
// Shared types, constants and helpers of the base run-length encoder.
package brle_pkg;

    localparam int MAX_RUN_DEF = 255;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] base_char;
        logic [7:0] base_quality;
        logic       read_end;
    } t_base_item;

    typedef struct packed {
        logic [7:0] run_char;
        logic [7:0] run_length;
        logic [7:0] run_mean_quality;
        logic       final_run;
    } t_run_item;

    // closed run waiting for its mean to be worked out
    typedef struct packed {
        logic [7:0]  run_char;
        logic [7:0]  run_length;
        logic [15:0] qual_sum;
        logic        final_run;
    } t_run_rec;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/brle_front.sv =====
// Front end: tracks the open run and turns closed runs into records.
module brle_front import brle_pkg::*; #(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_base_item i_item,
    output logic       o_stall,
    input  logic       i_q_full,
    output logic       o_push,
    output t_run_rec   o_push_rec
);

    localparam int SPLIT_I = (MAX_RUN > 255) ? 255 : ((MAX_RUN < 1) ? 1 : MAX_RUN);
    localparam logic [7:0] SPLIT = 8'(SPLIT_I);

    logic [7:0]  r_char,  n_char;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_sum,   n_sum;
    logic        r_open,  n_open;
    logic        r_pend_v, n_pend_v;
    t_run_rec    r_pend,  n_pend;

    logic        accept;
    logic        extend;
    logic        close_old;
    logic [7:0]  run_char;
    logic [7:0]  run_count;
    logic [15:0] run_sum;
    t_run_rec    rec_old;
    t_run_rec    rec_end;

    assign o_stall = r_pend_v || i_q_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        extend    = r_open && (i_item.base_char == r_char) && (r_count < SPLIT);
        close_old = r_open && !extend;
        if (extend) begin
            run_char  = r_char;
            run_count = r_count + 8'd1;
            run_sum   = r_sum + {8'd0, i_item.base_quality};
        end else begin
            run_char  = i_item.base_char;
            run_count = 8'd1;
            run_sum   = {8'd0, i_item.base_quality};
        end
        rec_old = '{run_char: to_upper(r_char), run_length: r_count,
                    qual_sum: r_sum, final_run: 1'b0};
        rec_end = '{run_char: to_upper(run_char), run_length: run_count,
                    qual_sum: run_sum, final_run: 1'b1};

        n_char     = r_char;
        n_count    = r_count;
        n_sum      = r_sum;
        n_open     = r_open;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        o_push     = 1'b0;
        o_push_rec = rec_old;

        if (accept) begin
            if (i_item.read_end) begin
                n_char  = 8'd0;
                n_count = 8'd0;
                n_sum   = 16'd0;
                n_open  = 1'b0;
            end else begin
                n_char  = run_char;
                n_count = run_count;
                n_sum   = run_sum;
                n_open  = 1'b1;
            end
            if (close_old) begin
                o_push     = 1'b1;
                o_push_rec = rec_old;
                // second record of this item is held in r_pend until the queue has room
                n_pend_v   = i_item.read_end;
                n_pend     = rec_end;
            end else if (i_item.read_end) begin
                o_push     = 1'b1;
                o_push_rec = rec_end;
            end
        end else if (r_pend_v && !i_q_full) begin
            o_push     = 1'b1;
            o_push_rec = r_pend;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char   <= '0;
            r_count  <= '0;
            r_sum    <= '0;
            r_open   <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_char   <= n_char;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_open   <= n_open;
            r_pend_v <= n_pend_v;
        end
        r_pend <= n_pend;
    end

endmodule

// ===== rtl/brle_queue.sv =====
// Short record queue between front and back end.
module brle_queue import brle_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_run_rec i_push_rec,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_not_empty,
    output t_run_rec o_head
);

    t_run_rec            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QPTR_W:0]     r_fill, n_fill;

    assign o_full      = (r_fill == (QPTR_W+1)'(QDEPTH));
    assign o_not_empty = (r_fill != '0);
    assign o_head      = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + 1'b1;
            2'b01:   n_fill = r_fill - 1'b1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_push_rec;
        end
    end

endmodule

// ===== rtl/brle_back.sv =====
// Back end: bit-serial mean-quality divider and output register.
module brle_back import brle_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_not_empty,
    input  t_run_rec  i_q_head,
    output logic      o_pop,
    output logic      o_valid,
    output t_run_item o_run,
    input  logic      i_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [2:0] r_step,  n_step;
    logic [7:0] r_rem,   n_rem;
    logic [7:0] r_quo,   n_quo;   // low dividend bits shift out, quotient bits in
    logic [7:0] r_char,  n_char;
    logic [7:0] r_len,   n_len;
    logic       r_final, n_final;

    logic [8:0] trial;
    logic [8:0] diff;
    logic       qbit;

    assign o_pop   = (r_state == S_IDLE) && i_q_not_empty;
    assign o_valid = (r_state == S_OUT);
    assign o_run   = '{run_char: r_char, run_length: r_len,
                       run_mean_quality: r_quo, final_run: r_final};

    always_comb begin
        trial = {r_rem, r_quo[7]};
        diff  = trial - {1'b0, r_len};
        qbit  = (trial >= {1'b0, r_len});

        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_char  = r_char;
        n_len   = r_len;
        n_final = r_final;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_not_empty) begin
                    // sum < len * 256, so the high byte is already a valid remainder
                    n_rem   = i_q_head.qual_sum[15:8];
                    n_quo   = i_q_head.qual_sum[7:0];
                    n_char  = i_q_head.run_char;
                    n_len   = i_q_head.run_length;
                    n_final = i_q_head.final_run;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = qbit ? diff[7:0] : trial[7:0];
                n_quo  = {r_quo[6:0], qbit};
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_char  <= n_char;
        r_len   <= n_len;
        r_final <= n_final;
    end

endmodule

// ===== rtl/base_run_length_encoder_top.sv =====
// Top level of the base run-length encoder.
// Takes one read character per item and emits one item per closed run: the
// run's character upper-cased, its length, the floor of its mean quality and
// a flag on the read's last run. Runs split at MAX_RUN characters (clamped to
// 1..255). The front end takes one item per cycle while its four-entry run
// queue has room; an item closing two runs holds the input until both are
// queued. Each run then passes the back end: queue pop, eight steps of the
// bit-serial divider, an output state held while i_stall is high; no new run
// is popped before the last is out. Long runs keep one item per cycle.
module base_run_length_encoder_top import brle_pkg::*; #(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_base_item i_item,
    output logic       o_stall,
    output logic       o_valid,
    output t_run_item  o_run,
    input  logic       i_stall
);

    logic     q_full;
    logic     q_push;
    t_run_rec q_push_rec;
    logic     q_pop;
    logic     q_not_empty;
    t_run_rec q_head;

    brle_front #(
        .MAX_RUN(MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .o_stall    (o_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_rec (q_push_rec)
    );

    brle_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_rec  (q_push_rec),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_head      (q_head)
    );

    brle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_head      (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_run         (o_run),
        .i_stall       (i_stall)
    );

endmodule

// ===== sim/base_run_length_encoder_top_tb.sv =====
// Self-checking testbench for the base run-length encoder: queued stimulus, run predictor.
`timescale 1ns / 100ps

module base_run_length_encoder_top_tb;
    import brle_pkg::*;

    localparam int RUN_CAP      = MAX_RUN_DEF;
    localparam int SPLIT_LEN    = (RUN_CAP > 255) ? 255 : ((RUN_CAP < 1) ? 1 : RUN_CAP);
    localparam logic [7:0] LC_FIRST = 8'h61;
    localparam logic [7:0] LC_LAST  = 8'h7a;
    localparam logic [7:0] CASE_GAP = 8'h20;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 60;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    t_base_item i_item  = '0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    t_run_item  o_run;

    base_run_length_encoder_top #(
        .MAX_RUN(RUN_CAP)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_item (i_item),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_run  (o_run),
        .i_stall(i_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  held_char  = '0;
    logic [7:0]  held_count = '0;
    logic [15:0] held_sum   = '0;
    logic        run_open   = 1'b0;

    t_base_item base_queue[$];
    t_run_item  runs_due[$];

    string       bases = "ACGTNacgtn";
    logic        quiet = 1'b0;
    logic        in_taken = 1'b0;
    logic [31:0] cycle_no = '0;
    int unsigned idle_run = 0;
    int unsigned src_gap = 0;
    int unsigned sink_stall = 0;
    int unsigned bases_sent = 0;
    int unsigned reads_sent = 0;
    int unsigned runs_seen = 0;
    int unsigned final_runs = 0;
    int unsigned split_runs = 0;
    int unsigned bad_runs = 0;

    // idling off during the quiet tail and for the top quarter of cycle_no[8:0]
    wire idle_ok = !quiet && (cycle_no[8:0] < 9'd384);

    task automatic close_run(input logic last);
        t_run_item r;
        r.run_char         = (held_char >= LC_FIRST && held_char <= LC_LAST) ?
                             held_char - CASE_GAP : held_char;
        r.run_length       = held_count;
        r.run_mean_quality = 8'(held_sum / held_count);
        r.final_run        = last;
        runs_due.push_back(r);
    endtask

    task automatic encode_base(input t_base_item it);
        if (run_open && (it.base_char != held_char || held_count >= SPLIT_LEN)) begin
            if (it.base_char == held_char) begin
                split_runs++;
            end
            close_run(1'b0);
            run_open = 1'b0;
        end
        if (run_open) begin
            held_count = held_count + 8'd1;
            held_sum   = held_sum + 16'(it.base_quality);
        end else begin
            held_char  = it.base_char;
            held_count = 8'd1;
            held_sum   = 16'(it.base_quality);
            run_open   = 1'b1;
        end
        if (it.read_end) begin
            close_run(1'b1);
            run_open   = 1'b0;
            held_char  = '0;
            held_count = '0;
            held_sum   = '0;
        end
    endtask

    function automatic logic [7:0] pick_quality();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_base(input logic [7:0] c, input logic [7:0] q, input logic e);
        t_base_item it;
        it.base_char    = c;
        it.base_quality = q;
        it.read_end     = e;
        base_queue.push_back(it);
        bases_sent++;
        if (e) begin
            reads_sent++;
        end
    endtask

    // one read built from runs; noisy reads use any byte and end reads early at random
    task automatic add_read(input int unsigned len, input logic noisy);
        logic [7:0]  c;
        int unsigned run_left;
        logic        e;
        c = '0;
        run_left = 0;
        for (int unsigned k = 0; k < len; k++) begin
            if (run_left == 0) begin
                c = noisy ? 8'($urandom_range(0, 255)) : bases[$urandom_range(0, 9)];
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30)
                                                        : $urandom_range(1, 6);
            end
            run_left--;
            e = (k == len - 1) || (noisy && $urandom_range(0, 5) == 0);
            add_base(c, pick_quality(), e);
        end
    endtask

    task automatic wait_all_done();
        while (base_queue.size() != 0 || i_valid || runs_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // sender: a new item only once the current one has been taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (base_queue.size() != 0) begin
                i_item  <= base_queue.pop_front();
                i_valid <= 1'b1;
                if (idle_ok && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(1, 7);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            i_stall <= 1'b1;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && !o_stall;
            cycle_no <= cycle_no + 1;
            if (o_valid && !i_stall) begin
                runs_seen++;
                if (runs_due.size() == 0) begin
                    bad_runs++;
                    $display("%0t: unexpected run: got char=%h len=%0d mean=%0d final=%b",
                             $time, o_run.run_char, o_run.run_length,
                             o_run.run_mean_quality, o_run.final_run);
                end else begin
                    if (o_run.run_char !== runs_due[0].run_char ||
                        o_run.run_length !== runs_due[0].run_length ||
                        o_run.run_mean_quality !== runs_due[0].run_mean_quality ||
                        o_run.final_run !== runs_due[0].final_run) begin
                        bad_runs++;
                        $display("%0t: run mismatch: exp char=%h len=%0d mean=%0d final=%b",
                                 $time, runs_due[0].run_char, runs_due[0].run_length,
                                 runs_due[0].run_mean_quality, runs_due[0].final_run);
                        $display("%0t:                got char=%h len=%0d mean=%0d final=%b",
                                 $time, o_run.run_char, o_run.run_length,
                                 o_run.run_mean_quality, o_run.final_run);
                    end
                    if (runs_due[0].final_run) begin
                        final_runs++;
                    end
                    void'(runs_due.pop_front());
                end
            end
            if (i_valid && !o_stall) begin
                encode_base(i_item);
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
            if (idle_run >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int unsigned mark;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first char, case-sensitive change, single-char reads, byte extremes
        add_base("A", 8'd0, 1'b0);
        add_base("A", 8'd255, 1'b0);
        add_base("a", 8'd1, 1'b0);
        add_base("a", 8'd2, 1'b1);
        add_base("z", 8'd255, 1'b1);
        add_base(8'h00, 8'd0, 1'b0);
        add_base(8'hff, 8'd255, 1'b0);
        add_base(8'hff, 8'd0, 1'b1);
        add_base(8'h60, 8'd7, 1'b0);
        add_base(8'h7b, 8'd8, 1'b0);
        add_base("Z", 8'd9, 1'b0);
        add_base("@", 8'd10, 1'b1);
        add_base("c", 8'd100, 1'b0);
        add_base("c", 8'd101, 1'b0);
        add_base("c", 8'd103, 1'b0);
        add_base("G", 8'd77, 1'b1);
        add_base("t", 8'd255, 1'b0);
        add_base("t", 8'd254, 1'b0);
        add_base("T", 8'd3, 1'b1);
        // hold the sender until every run has come out
        wait_all_done();

        // full-length runs: a split that continues, and one closed by the read end
        for (int k = 0; k < SPLIT_LEN; k++) begin
            add_base("g", 8'd255, 1'b0);
        end
        repeat (3) add_base("g", pick_quality(), 1'b0);
        add_base("T", pick_quality(), 1'b1);
        for (int k = 0; k < SPLIT_LEN; k++) begin
            add_base("C", 8'd255, k == SPLIT_LEN - 1);
        end

        mark = bases_sent;
        while (bases_sent - mark < 800) begin
            add_read($urandom_range(1, 40), $urandom_range(0, 9) == 0);
        end
        while (base_queue.size() != 0) begin
            @(posedge i_clk);
        end
        quiet = 1'b1;
        mark = bases_sent;
        while (bases_sent - mark < 250) begin
            add_read($urandom_range(1, 40), $urandom_range(0, 9) == 0);
        end

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bases in %0d reads; %0d runs out, %0d read-final,",
                 bases_sent, reads_sent, runs_seen, final_runs);
        $display("%0d full-length splits; covered case changes, byte extremes and idling.",
                 split_runs);
        if (bad_runs == 0 && runs_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
